@@ rtl/core/cimavg_pkg.sv @@
// Shared types and constants of the clamped IMU moving average.
`default_nettype none
package cimavg_pkg;

  localparam int NUM_AXES   = 6;
  localparam int ACCEL_AXES = 3;
  localparam int WIN_BITS   = 7;
  localparam int CFG_IDX_W  = 3;

  // fixed point: one unit is 1/1024
  localparam int FIX_ONE      = 1024;
  localparam int ACCEL_LIMIT  = 10;
  localparam int GYRO_LIMIT   = 4;
  localparam int WINDOW_RESET = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCEL_LOW  = 3'd0,
    REG_ACCEL_HIGH = 3'd1,
    REG_GYRO_LOW   = 3'd2,
    REG_GYRO_HIGH  = 3'd3,
    REG_WINDOW     = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPD,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef enum logic {
    MODE_SAMPLE = 1'b0,
    MODE_TICK   = 1'b1
  } mode_e;

endpackage
`default_nettype wire

@@ rtl/core/cimavg_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module cimavg_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/clamped_imu_moving_average_top.sv @@
// Sample: ring read of the expiring entry on accept, then sum update and write-back.
// Tick with a full window: an accept step, then one quotient bit per cycle in six
// parallel restoring dividers over SUM_W bits, then an output load held while stalled.
// Tick without a full window: accepted with no result. Defaults give SUM_W = 22.
// Reset loads the register defaults and empties history; ring contents stay undefined.
`default_nettype none
module clamped_imu_moving_average_top
  import cimavg_pkg::*;
#(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          mode_i,
  input  wire logic signed [SAMPLE_BITS-1:0] accel_x_i,
  input  wire logic signed [SAMPLE_BITS-1:0] accel_y_i,
  input  wire logic signed [SAMPLE_BITS-1:0] accel_z_i,
  input  wire logic signed [SAMPLE_BITS-1:0] gyro_x_i,
  input  wire logic signed [SAMPLE_BITS-1:0] gyro_y_i,
  input  wire logic signed [SAMPLE_BITS-1:0] gyro_z_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed      [SAMPLE_BITS-1:0] avg_accel_x_o,
  output logic signed      [SAMPLE_BITS-1:0] avg_accel_y_o,
  output logic signed      [SAMPLE_BITS-1:0] avg_accel_z_o,
  output logic signed      [SAMPLE_BITS-1:0] avg_gyro_x_o,
  output logic signed      [SAMPLE_BITS-1:0] avg_gyro_y_o,
  output logic signed      [SAMPLE_BITS-1:0] avg_gyro_z_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic        [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic        [SAMPLE_BITS-1:0] cfg_data_i
);

  localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int DCNT_W = $clog2(SUM_W + 1);
  localparam int MEM_W  = NUM_AXES * SAMPLE_BITS;

  // configuration
  logic signed [SAMPLE_BITS-1:0] accel_low_q, accel_high_q, gyro_low_q, gyro_high_q;
  logic        [WIN_BITS-1:0]    window_q;
  logic                          cfg_write;
  logic                          restart;

  // history control and sums
  logic        [PTR_W-1:0]  ptr_q, ptr_d;
  logic        [CNT_W-1:0]  fill_q, fill_d;
  logic signed [SUM_W-1:0]  sum_q [NUM_AXES];
  logic signed [SUM_W-1:0]  sum_d [NUM_AXES];
  logic        [CNT_W-1:0]  win_eff;
  logic        [CNT_W:0]    old_sum;
  logic        [PTR_W-1:0]  old_ptr;
  logic                     full;

  // datapath
  logic signed [SAMPLE_BITS-1:0] in_samp [NUM_AXES];
  logic signed [SAMPLE_BITS-1:0] clamp_d [NUM_AXES];
  logic signed [SAMPLE_BITS-1:0] clamp_q [NUM_AXES];
  logic signed [SAMPLE_BITS-1:0] lim_lo, lim_hi;
  logic        [MEM_W-1:0]       mem_wdata, mem_rdata;

  // divider lanes
  logic        [SUM_W-1:0]       quo_q [NUM_AXES];
  logic        [CNT_W-1:0]       rem_q [NUM_AXES];
  logic                          neg_q [NUM_AXES];
  logic        [CNT_W:0]         rem_shift [NUM_AXES];
  logic                          qbit [NUM_AXES];
  logic        [SUM_W-1:0]       quo_signed [NUM_AXES];
  logic        [DCNT_W-1:0]      dcnt_q;
  logic signed [SAMPLE_BITS-1:0] avg_q [NUM_AXES];
  logic                          out_valid_q;

  // control
  state_e state_q, state_d;
  logic   take_sample, take_tick, do_upd, div_step, load_out, can_load;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;
  assign restart     = cfg_write && (cfg_index_i <= REG_WINDOW);

  always_comb begin
    if (window_q == '0) begin
      win_eff = CNT_W'(1);
    end else if (32'(window_q) > MAX_WINDOW) begin
      win_eff = CNT_W'(MAX_WINDOW);
    end else begin
      win_eff = CNT_W'(window_q);
    end
  end

  assign full = fill_q >= win_eff;

  // entry that drops out of the window: (ptr + MAX - w) mod MAX
  always_comb begin
    old_sum = (CNT_W + 1)'(ptr_q) + (CNT_W + 1)'(MAX_WINDOW) - (CNT_W + 1)'(win_eff);
    if (old_sum >= (CNT_W + 1)'(MAX_WINDOW)) begin
      old_sum = old_sum - (CNT_W + 1)'(MAX_WINDOW);
    end
    old_ptr = old_sum[PTR_W-1:0];
  end

  assign in_samp[0] = accel_x_i;
  assign in_samp[1] = accel_y_i;
  assign in_samp[2] = accel_z_i;
  assign in_samp[3] = gyro_x_i;
  assign in_samp[4] = gyro_y_i;
  assign in_samp[5] = gyro_z_i;

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      lim_lo = (k < ACCEL_AXES) ? accel_low_q : gyro_low_q;
      lim_hi = (k < ACCEL_AXES) ? accel_high_q : gyro_high_q;
      if (in_samp[k] < lim_lo) begin
        clamp_d[k] = lim_lo;
      end else if (in_samp[k] > lim_hi) begin
        clamp_d[k] = lim_hi;
      end else begin
        clamp_d[k] = in_samp[k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      mem_wdata[k*SAMPLE_BITS +: SAMPLE_BITS] = clamp_q[k];
    end
  end

  // control FSM
  assign can_load = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    in_stall_o  = 1'b1;
    take_sample = 1'b0;
    take_tick   = 1'b0;
    do_upd      = 1'b0;
    div_step    = 1'b0;
    load_out    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (mode_i == MODE_SAMPLE) begin
            take_sample = 1'b1;
            state_d     = ST_UPD;
          end else if (full) begin
            take_tick = 1'b1;
            state_d   = ST_DIV;
          end
        end
      end
      ST_UPD: begin
        do_upd  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_DIV: begin
        div_step = 1'b1;
        if (dcnt_q == DCNT_W'(SUM_W - 1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (can_load) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ring of clamped samples
  cimavg_ram #(
    .WIDTH(MEM_W),
    .DEPTH(MAX_WINDOW)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (do_upd),
    .waddr_i(ptr_q),
    .wdata_i(mem_wdata),
    .re_i   (take_sample),
    .raddr_i(old_ptr),
    .rdata_o(mem_rdata)
  );

  // running sums: add the new sample, drop the expiring one once the window is full
  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      sum_d[k] = sum_q[k] + SUM_W'(clamp_q[k]);
      if (full) begin
        sum_d[k] = sum_d[k] - SUM_W'($signed(mem_rdata[k*SAMPLE_BITS +: SAMPLE_BITS]));
      end
    end
    ptr_d  = (32'(ptr_q) == MAX_WINDOW - 1) ? '0 : ptr_q + PTR_W'(1);
    fill_d = (32'(fill_q) < MAX_WINDOW) ? fill_q + CNT_W'(1) : fill_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_low_q  <= SAMPLE_BITS'(-ACCEL_LIMIT * FIX_ONE);
      accel_high_q <= SAMPLE_BITS'(ACCEL_LIMIT * FIX_ONE);
      gyro_low_q   <= SAMPLE_BITS'(-GYRO_LIMIT * FIX_ONE);
      gyro_high_q  <= SAMPLE_BITS'(GYRO_LIMIT * FIX_ONE);
      window_q     <= WIN_BITS'(WINDOW_RESET);
      ptr_q        <= '0;
      fill_q       <= '0;
      for (int k = 0; k < NUM_AXES; k++) begin
        sum_q[k] <= '0;
      end
    end else if (restart) begin
      unique case (cfg_index_i)
        REG_ACCEL_LOW:  accel_low_q  <= cfg_data_i;
        REG_ACCEL_HIGH: accel_high_q <= cfg_data_i;
        REG_GYRO_LOW:   gyro_low_q   <= cfg_data_i;
        REG_GYRO_HIGH:  gyro_high_q  <= cfg_data_i;
        REG_WINDOW:     window_q     <= cfg_data_i[WIN_BITS-1:0];
        default: ;
      endcase
      ptr_q  <= '0;
      fill_q <= '0;
      for (int k = 0; k < NUM_AXES; k++) begin
        sum_q[k] <= '0;
      end
    end else if (do_upd) begin
      ptr_q  <= ptr_d;
      fill_q <= fill_d;
      for (int k = 0; k < NUM_AXES; k++) begin
        sum_q[k] <= sum_d[k];
      end
    end
  end

  // restoring division of |sum| by the window, one quotient bit per cycle
  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      rem_shift[k]  = {rem_q[k], quo_q[k][SUM_W-1]};
      qbit[k]       = rem_shift[k] >= {1'b0, win_eff};
      quo_signed[k] = neg_q[k] ? -quo_q[k] : quo_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_sample) begin
      clamp_q <= clamp_d;
    end
    for (int k = 0; k < NUM_AXES; k++) begin
      if (take_tick) begin
        neg_q[k] <= sum_q[k][SUM_W-1];
        quo_q[k] <= sum_q[k][SUM_W-1] ? SUM_W'(-sum_q[k]) : SUM_W'(sum_q[k]);
        rem_q[k] <= '0;
      end else if (div_step) begin
        quo_q[k] <= {quo_q[k][SUM_W-2:0], qbit[k]};
        rem_q[k] <= qbit[k] ? CNT_W'(rem_shift[k] - {1'b0, win_eff})
                            : rem_shift[k][CNT_W-1:0];
      end
      if (load_out) begin
        avg_q[k] <= quo_signed[k][SAMPLE_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take_tick) begin
        dcnt_q <= '0;
      end else if (div_step) begin
        dcnt_q <= dcnt_q + DCNT_W'(1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign avg_accel_x_o = avg_q[0];
  assign avg_accel_y_o = avg_q[1];
  assign avg_accel_z_o = avg_q[2];
  assign avg_gyro_x_o  = avg_q[3];
  assign avg_gyro_y_o  = avg_q[4];
  assign avg_gyro_z_o  = avg_q[5];

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= MAX_WINDOW)
    else $error("fill count above ring depth");

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ptr_q) < MAX_WINDOW)
    else $error("write pointer outside ring");

  a_sample_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_sample |=> (state_q == ST_UPD) && !in_stall_o == 1'b0)
    else $error("sample not followed by write-back");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_OUT)
    else $error("result shown without finished division");
`endif

endmodule
`default_nettype wire

@@ bench/imu_average_checker.sv @@
// Checker for the clamped IMU moving average: predicts windowed means and compares results.
`default_nettype none
module imu_average_checker
  import cimavg_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_stall_i,
  input  wire logic              mode_i,
  input  wire logic signed [15:0] accel_x_i,
  input  wire logic signed [15:0] accel_y_i,
  input  wire logic signed [15:0] accel_z_i,
  input  wire logic signed [15:0] gyro_x_i,
  input  wire logic signed [15:0] gyro_y_i,
  input  wire logic signed [15:0] gyro_z_i,
  input  wire logic              out_valid_i,
  input  wire logic              out_stall_i,
  input  wire logic signed [15:0] avg_accel_x_i,
  input  wire logic signed [15:0] avg_accel_y_i,
  input  wire logic signed [15:0] avg_accel_z_i,
  input  wire logic signed [15:0] avg_gyro_x_i,
  input  wire logic signed [15:0] avg_gyro_y_i,
  input  wire logic signed [15:0] avg_gyro_z_i,
  input  wire logic              cfg_valid_i,
  input  wire logic              cfg_ready_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [15:0]       cfg_data_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  localparam int MAX_WINDOW = 64;
  localparam int SHOW_LIMIT = 10;

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic signed [15:0] gz;
  } imu_mean_t;

  logic signed [15:0] accel_lo, accel_hi, gyro_lo, gyro_hi;
  logic [WIN_BITS-1:0] win_reg;

  logic signed [15:0] accel_ring [MAX_WINDOW][ACCEL_AXES];
  logic signed [15:0] gyro_ring  [MAX_WINDOW][ACCEL_AXES];
  logic [5:0]          wr_ptr;
  logic [WIN_BITS-1:0] fill;
  logic signed [21:0]  accel_sum [ACCEL_AXES];
  logic signed [21:0]  gyro_sum  [ACCEL_AXES];

  imu_mean_t mean_q [$];

  function automatic logic signed [15:0] clip_to(logic signed [15:0] x,
                                                 logic signed [15:0] lo,
                                                 logic signed [15:0] hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  function automatic int window_len();
    if (win_reg == 0) return 1;
    if (win_reg > MAX_WINDOW) return MAX_WINDOW;
    return int'(win_reg);
  endfunction

  task automatic restart_history();
    wr_ptr = '0;
    fill   = '0;
    for (int k = 0; k < ACCEL_AXES; k++) begin
      accel_sum[k] = '0;
      gyro_sum[k]  = '0;
    end
  endtask

  task automatic write_setting(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    case (idx)
      REG_ACCEL_LOW:  accel_lo = data;
      REG_ACCEL_HIGH: accel_hi = data;
      REG_GYRO_LOW:   gyro_lo  = data;
      REG_GYRO_HIGH:  gyro_hi  = data;
      REG_WINDOW:     win_reg  = data[WIN_BITS-1:0];
      default:        return;
    endcase
    restart_history();
  endtask

  task automatic fold_sample(logic signed [15:0] a [ACCEL_AXES],
                             logic signed [15:0] g [ACCEL_AXES]);
    int w, p, oldest;
    bit full;
    logic signed [15:0] ca, cg;
    w      = window_len();
    p      = int'(wr_ptr);
    oldest = (p + MAX_WINDOW - w) % MAX_WINDOW;
    full   = int'(fill) >= w;
    for (int k = 0; k < ACCEL_AXES; k++) begin
      ca = clip_to(a[k], accel_lo, accel_hi);
      cg = clip_to(g[k], gyro_lo, gyro_hi);
      // drop the expiring entry before it is overwritten
      if (full) begin
        accel_sum[k] = accel_sum[k] - accel_ring[oldest][k];
        gyro_sum[k]  = gyro_sum[k] - gyro_ring[oldest][k];
      end
      accel_ring[p][k] = ca;
      gyro_ring[p][k]  = cg;
      accel_sum[k] = accel_sum[k] + ca;
      gyro_sum[k]  = gyro_sum[k] + cg;
    end
    wr_ptr = wr_ptr + 1'b1;
    if (fill < MAX_WINDOW) fill = fill + 1'b1;
  endtask

  function automatic logic signed [15:0] mean_of(logic signed [21:0] sum, int w);
    int q;
    q = int'(sum) / w;
    return q[15:0];
  endfunction

  task automatic check_axis(string name, logic signed [15:0] want, logic signed [15:0] got);
    if (got !== want) begin
      fail_count_o++;
      if (fail_count_o <= SHOW_LIMIT)
        $display("mismatch %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    imu_mean_t want;
    logic signed [15:0] a [ACCEL_AXES];
    logic signed [15:0] g [ACCEL_AXES];
    int w;
    if (!rst_ni) begin
      accel_lo = -16'sd10240;
      accel_hi = 16'sd10240;
      gyro_lo  = -16'sd4096;
      gyro_hi  = 16'sd4096;
      win_reg  = WIN_BITS'(WINDOW_RESET);
      restart_history();
      mean_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (mean_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= SHOW_LIMIT)
            $display("mismatch: result with none expected");
        end else begin
          want = mean_q.pop_front();
          check_axis("avg_accel_x", want.ax, avg_accel_x_i);
          check_axis("avg_accel_y", want.ay, avg_accel_y_i);
          check_axis("avg_accel_z", want.az, avg_accel_z_i);
          check_axis("avg_gyro_x", want.gx, avg_gyro_x_i);
          check_axis("avg_gyro_y", want.gy, avg_gyro_y_i);
          check_axis("avg_gyro_z", want.gz, avg_gyro_z_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) write_setting(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_i) begin
        if (mode_i == MODE_TICK) begin
          w = window_len();
          if (int'(fill) >= w) begin
            want.ax = mean_of(accel_sum[0], w);
            want.ay = mean_of(accel_sum[1], w);
            want.az = mean_of(accel_sum[2], w);
            want.gx = mean_of(gyro_sum[0], w);
            want.gy = mean_of(gyro_sum[1], w);
            want.gz = mean_of(gyro_sum[2], w);
            mean_q.insert(mean_q.size(), want);
          end
        end else begin
          a[0] = accel_x_i; a[1] = accel_y_i; a[2] = accel_z_i;
          g[0] = gyro_x_i;  g[1] = gyro_y_i;  g[2] = gyro_z_i;
          fold_sample(a, g);
        end
      end
      pending_o = mean_q.size();
    end
  end

endmodule
`default_nettype wire

@@ bench/tb_clamped_imu_moving_average_top.sv @@
// Testbench top for the clamped IMU moving average: clock, reset, stimulus and verdict.
`default_nettype none
module tb_clamped_imu_moving_average_top;
  import cimavg_pkg::*;

  localparam int TARGET_ITEMS  = 1550;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 1500000;
  localparam int SPARE_IDX_LO  = REG_WINDOW + 1;
  localparam int SPARE_IDX_HI  = (1 << CFG_IDX_W) - 1;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   in_valid  = 1'b0;
  logic                   mode      = MODE_SAMPLE;
  logic signed [15:0]     accel_x   = '0;
  logic signed [15:0]     accel_y   = '0;
  logic signed [15:0]     accel_z   = '0;
  logic signed [15:0]     gyro_x    = '0;
  logic signed [15:0]     gyro_y    = '0;
  logic signed [15:0]     gyro_z    = '0;
  logic                   out_stall = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [15:0]            cfg_data  = '0;

  logic               in_stall_o, out_valid_o, cfg_ready_o;
  logic signed [15:0] avg_accel_x_o, avg_accel_y_o, avg_accel_z_o;
  logic signed [15:0] avg_gyro_x_o, avg_gyro_y_o, avg_gyro_z_o;

  int  fail_count;
  int  pending;
  int  items_sent = 0;
  int  cycle_cnt  = 0;
  int  stall_left = 0;
  bit  calm       = 1'b0;

  always #2 clk_i = ~clk_i;

  clamped_imu_moving_average_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode),
    .accel_x_i     (accel_x),
    .accel_y_i     (accel_y),
    .accel_z_i     (accel_z),
    .gyro_x_i      (gyro_x),
    .gyro_y_i      (gyro_y),
    .gyro_z_i      (gyro_z),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .avg_accel_x_o (avg_accel_x_o),
    .avg_accel_y_o (avg_accel_y_o),
    .avg_accel_z_o (avg_accel_z_o),
    .avg_gyro_x_o  (avg_gyro_x_o),
    .avg_gyro_y_o  (avg_gyro_y_o),
    .avg_gyro_z_o  (avg_gyro_z_o),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  imu_average_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall_o),
    .mode_i        (mode),
    .accel_x_i     (accel_x),
    .accel_y_i     (accel_y),
    .accel_z_i     (accel_z),
    .gyro_x_i      (gyro_x),
    .gyro_y_i      (gyro_y),
    .gyro_z_i      (gyro_z),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall),
    .avg_accel_x_i (avg_accel_x_o),
    .avg_accel_y_i (avg_accel_y_o),
    .avg_accel_z_i (avg_accel_z_o),
    .avg_gyro_x_i  (avg_gyro_x_o),
    .avg_gyro_y_i  (avg_gyro_y_o),
    .avg_gyro_z_i  (avg_gyro_z_o),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'(($urandom_range(0, 1) ? 1 : -1) * (10240 + $urandom_range(0, 3) - 1));
      4, 5: return 16'(int'($urandom_range(0, 10000)) - 5000);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_limit();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [WIN_BITS-1:0] pick_window();
    int r;
    r = $urandom_range(0, 19);
    case (r)
      0: return WIN_BITS'(0);
      1: return WIN_BITS'(1);
      2: return WIN_BITS'(127);
      3: return WIN_BITS'(64);
      4: return WIN_BITS'(65);
      5: return WIN_BITS'(63);
      6, 7, 8, 9, 10, 11, 12, 13: return WIN_BITS'($urandom_range(1, 8));
      default: return WIN_BITS'($urandom_range(1, 32));
    endcase
  endfunction

  // send one word: ax, ay, az, gx, gy, gz from the top of the vector down
  task automatic put_word(input mode_e m, input logic [95:0] axes);
    int gap;
    gap = calm ? 0 : gap_len();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      {accel_x, accel_y, accel_z} <= 48'({$urandom, $urandom});
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    mode     <= m;
    {accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z} <= axes;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_sample();
    logic [95:0] v;
    for (int k = 0; k < 6; k++) v[16*k +: 16] = pick_sample();
    put_word(MODE_SAMPLE, v);
  endtask

  task automatic send_tick();
    put_word(MODE_TICK, {$urandom, $urandom, $urandom});
  endtask

  // hold the input channel until every result is out and the block has drained
  task automatic settle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_limits(input logic [CFG_IDX_W-1:0] lo_idx,
                              input logic [CFG_IDX_W-1:0] hi_idx);
    logic [15:0] lo, hi;
    if ($urandom_range(0, 3) != 0) begin
      lo = 16'(-int'($urandom_range(1, 20000)));
      hi = 16'($urandom_range(1, 20000));
    end else begin
      lo = pick_limit();
      hi = pick_limit();
    end
    if ($urandom_range(0, 3) != 0) write_reg(lo_idx, lo);
    if ($urandom_range(0, 3) != 0) write_reg(hi_idx, hi);
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (calm || out_stall) begin
      out_stall  <= 1'b0;
      stall_left = calm ? 0 : $urandom_range(0, 6);
    end else begin
      out_stall  <= ($urandom_range(0, 2) == 0);
      stall_left = gap_len();
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [WIN_BITS-1:0] win;
    int eff, n_items;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings, window of three: too few samples, then clamped extremes
    send_tick();
    put_word(MODE_SAMPLE, {6{16'h7FFF}});
    put_word(MODE_SAMPLE, {6{16'h8000}});
    put_word(MODE_SAMPLE, {6{16'h0000}});
    send_tick();
    put_word(MODE_SAMPLE, {16'sd1, -16'sd1, 16'sd3, -16'sd3, 16'sd4097, -16'sd4097});
    send_tick();

    // full accel range, crossed gyro limits, window of two
    settle();
    write_reg(REG_ACCEL_LOW, 16'h8000);
    write_reg(REG_ACCEL_HIGH, 16'h7FFF);
    write_reg(REG_GYRO_LOW, 16'sd500);
    write_reg(REG_GYRO_HIGH, -16'sd500);
    write_reg(REG_WINDOW, 16'd2);
    put_word(MODE_SAMPLE, {6{16'h7FFF}});
    put_word(MODE_SAMPLE, {6{16'h8000}});
    send_tick();
    put_word(MODE_SAMPLE, {-16'sd7, -16'sd3, 16'sd5, 16'sd0, 16'sd600, -16'sd600});
    send_tick();

    // a write past the register list leaves history alone
    settle();
    write_reg(3'(SPARE_IDX_LO), 16'($urandom));
    send_tick();
    settle();
    write_reg(REG_WINDOW, 16'd0);
    put_word(MODE_SAMPLE, {-16'sd9, 16'sd9, -16'sd1, 16'sd499, -16'sd499, 16'sd1});
    send_tick();

    while (items_sent < TARGET_ITEMS) begin
      settle();
      write_limits(REG_ACCEL_LOW, REG_ACCEL_HIGH);
      write_limits(REG_GYRO_LOW, REG_GYRO_HIGH);
      win = pick_window();
      write_reg(REG_WINDOW, {9'($urandom_range(0, 511)), win});
      if ($urandom_range(0, 5) == 0)
        write_reg(3'($urandom_range(SPARE_IDX_LO, SPARE_IDX_HI)), 16'($urandom));
      calm = ($urandom_range(0, 3) == 0);
      eff  = (win == 0) ? 1 : ((win > 64) ? 64 : int'(win));
      n_items = 2 * eff + $urandom_range(8, 40);
      // some long runs so the ring pointer wraps under small windows
      if ($urandom_range(0, 4) == 0) n_items += 80;
      repeat (n_items) begin
        if ($urandom_range(0, 3) == 0) send_tick();
        else send_sample();
      end
      calm = 1'b0;
    end

    settle();
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
rtl/core/cimavg_pkg.sv
rtl/core/cimavg_ram.sv
rtl/core/clamped_imu_moving_average_top.sv
bench/imu_average_checker.sv
bench/tb_clamped_imu_moving_average_top.sv
